/* hw/rtl/gswv_pkg.sv */
package gswv_pkg;

  localparam int DEF_MAX_ROW_LENGTH = 1024;
  localparam int DEF_MAX_RADIUS     = 7;
  localparam int DEF_SAMPLE_BITS    = 16;

  // configuration register fields
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LEN_W      = 11;
  localparam int RAD_W      = 3;
  localparam int LVL_W      = 16;
  localparam int VAR_W      = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LEVEL  = 3'd4;

  localparam longint unsigned VAR_MAX = 64'h7FFF_FFFF;

  typedef struct packed {
    logic take;        // latch accepted sample
    logic row_wr;      // write sample into row store
    logic row_rd;      // read row store at rd_slot
    logic use_sample;  // first tap comes from the sample register
    logic col_clr;
    logic col_mul;
    logic col_acc;
    logic col_wr;      // write column sums
    logic win_clr;
    logic win_rd;
    logic win_acc;
    logic fin_mul;
    logic fin_eval;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic gate;
    logic div_last;
  } sta_t;

endpackage

/* hw/rtl/gswv_ctrl.sv */
module gswv_ctrl #(
  parameter int MAX_ROW_LENGTH = gswv_pkg::DEF_MAX_ROW_LENGTH,
  parameter int MAX_RADIUS     = gswv_pkg::DEF_MAX_RADIUS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             frame_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gswv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gswv_pkg::CFG_DATA_W-1:0]  cfg_data,
  output gswv_pkg::cmd_t                   cmd,
  input  gswv_pkg::sta_t                   sta,
  output logic [$clog2(MAX_ROW_LENGTH)-1:0] col_l,
  output logic [$clog2(2*MAX_RADIUS+1)-1:0] slot_l,
  output logic [$clog2(2*MAX_RADIUS+1)-1:0] rd_slot,
  output logic [$clog2(MAX_ROW_LENGTH)-1:0] win_col,
  output logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1)-1:0] n,
  output logic [gswv_pkg::LVL_W-1:0]       lower,
  output logic [gswv_pkg::LVL_W-1:0]       upper
);
  import gswv_pkg::*;

  localparam int ROW_SLOTS = 2*MAX_RADIUS + 1;
  localparam int SW   = $clog2(ROW_SLOTS);
  localparam int CB   = $clog2(MAX_ROW_LENGTH);
  localparam int LL_W = $clog2(MAX_ROW_LENGTH + 1);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int N_W  = $clog2(ROW_SLOTS*ROW_SLOTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROWWR = 4'd1;
  localparam logic [3:0] S_CISS  = 4'd2;
  localparam logic [3:0] S_CMUL  = 4'd3;
  localparam logic [3:0] S_CACC  = 4'd4;
  localparam logic [3:0] S_CWR   = 4'd5;
  localparam logic [3:0] S_WISS  = 4'd6;
  localparam logic [3:0] S_WACC  = 4'd7;
  localparam logic [3:0] S_FMUL  = 4'd8;
  localparam logic [3:0] S_FEVAL = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]       state, state_next;
  logic [LEN_W-1:0] row_length;
  logic [RAD_W-1:0] horiz_radius, vert_radius;
  logic [CB-1:0]    col_cnt;
  logic [SW-1:0]    row_cnt, slot_cnt, k;
  logic             fe_l, rows_ok_l, valid_l;

  logic [LL_W-1:0]  len_e;
  logic [RW-1:0]    xr, yr;
  logic [RW:0]      xr2, yr2;
  logic [CB-1:0]    col_eff;
  logic             accept, cfg_wr, rows_ok, out_free;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready &&
                     (cfg_index == CFG_ROW_LENGTH || cfg_index == CFG_HORIZ_RADIUS ||
                      cfg_index == CFG_VERT_RADIUS || cfg_index == CFG_LOWER_LEVEL ||
                      cfg_index == CFG_UPPER_LEVEL);
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (row_length == '0) begin
      len_e = LL_W'(1);
    end else if (int'(row_length) > MAX_ROW_LENGTH) begin
      len_e = LL_W'(MAX_ROW_LENGTH);
    end else begin
      len_e = LL_W'(row_length);
    end
    xr  = (int'(horiz_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(horiz_radius);
    yr  = (int'(vert_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(vert_radius);
    xr2 = {xr, 1'b0};
    yr2 = {yr, 1'b0};
    n   = N_W'({1'b0, xr2} + 1'b1) * N_W'({1'b0, yr2} + 1'b1);
    col_eff = (LL_W'(col_cnt) >= len_e) ? '0 : col_cnt;
    rows_ok = (row_cnt >= yr2);
  end

  // config registers and frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length   <= LEN_W'(1024);
      horiz_radius <= RAD_W'(1);
      vert_radius  <= RAD_W'(1);
      lower        <= '0;
      upper        <= '1;
      col_cnt      <= '0;
      row_cnt      <= '0;
      slot_cnt     <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_ROW_LENGTH:   row_length   <= cfg_data[LEN_W-1:0];
        CFG_HORIZ_RADIUS: horiz_radius <= cfg_data[RAD_W-1:0];
        CFG_VERT_RADIUS:  vert_radius  <= cfg_data[RAD_W-1:0];
        CFG_LOWER_LEVEL:  lower        <= cfg_data[LVL_W-1:0];
        CFG_UPPER_LEVEL:  upper        <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
      col_cnt  <= '0;
      row_cnt  <= '0;
      slot_cnt <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col_cnt  <= '0;
        row_cnt  <= '0;
        slot_cnt <= '0;
      end else if (LL_W'(col_eff) + LL_W'(1) >= len_e) begin
        col_cnt <= '0;
        if (int'(row_cnt) < 2*MAX_RADIUS) row_cnt <= row_cnt + 1'b1;
        slot_cnt <= (int'(slot_cnt) == ROW_SLOTS-1) ? '0 : slot_cnt + 1'b1;
      end else begin
        col_cnt <= col_eff + 1'b1;
      end
    end
  end

  // per-item latches and loop counters
  always_ff @(posedge clk) begin
    if (accept) begin
      col_l     <= col_eff;
      slot_l    <= (int'(slot_cnt) >= ROW_SLOTS) ? '0 : slot_cnt;
      fe_l      <= frame_end;
      rows_ok_l <= rows_ok;
      valid_l   <= rows_ok && (col_eff >= CB'(xr2));
    end
    case (state)
      S_ROWWR: begin
        k       <= '0;
        rd_slot <= slot_l;
      end
      S_CACC: begin
        k       <= k + 1'b1;
        rd_slot <= (rd_slot == '0) ? SW'(ROW_SLOTS-1) : rd_slot - 1'b1;
      end
      S_CWR:  win_col <= col_l - CB'(xr2);
      S_WACC: win_col <= win_col + 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.take = accept;
        if (accept) state_next = S_ROWWR;
      end
      S_ROWWR: begin
        cmd.row_wr  = 1'b1;
        cmd.col_clr = 1'b1;
        state_next  = rows_ok_l ? S_CISS : S_IDLE;
      end
      S_CISS: begin
        cmd.row_rd = 1'b1;
        state_next = S_CMUL;
      end
      S_CMUL: begin
        cmd.col_mul    = 1'b1;
        cmd.use_sample = (k == '0);
        state_next     = S_CACC;
      end
      S_CACC: begin
        cmd.col_acc = 1'b1;
        state_next  = ((RW+1)'(k) == yr2) ? S_CWR : S_CISS;
      end
      S_CWR: begin
        cmd.col_wr  = 1'b1;
        cmd.win_clr = 1'b1;
        state_next  = valid_l ? S_WISS : S_IDLE;
      end
      S_WISS: begin
        cmd.win_rd = 1'b1;
        state_next = S_WACC;
      end
      S_WACC: begin
        cmd.win_acc = 1'b1;
        state_next  = (win_col == col_l) ? S_FMUL : S_WISS;
      end
      S_FMUL: begin
        cmd.fin_mul = 1'b1;
        state_next  = S_FEVAL;
      end
      S_FEVAL: begin
        cmd.fin_eval = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sta.gate || sta.div_last) state_next = S_OUT;
      end
      S_OUT: begin
        cmd.out_load = out_free;
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) last <= fe_l;
  end

endmodule

/* hw/rtl/gswv_datapath.sv */
module gswv_datapath #(
  parameter int MAX_ROW_LENGTH = gswv_pkg::DEF_MAX_ROW_LENGTH,
  parameter int MAX_RADIUS     = gswv_pkg::DEF_MAX_RADIUS,
  parameter int SAMPLE_BITS    = gswv_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gswv_pkg::cmd_t                    cmd,
  output gswv_pkg::sta_t                    sta,
  input  logic [SAMPLE_BITS-1:0]            sample,
  input  logic [$clog2(MAX_ROW_LENGTH)-1:0] col_l,
  input  logic [$clog2(2*MAX_RADIUS+1)-1:0] slot_l,
  input  logic [$clog2(2*MAX_RADIUS+1)-1:0] rd_slot,
  input  logic [$clog2(MAX_ROW_LENGTH)-1:0] win_col,
  input  logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1)-1:0] n,
  input  logic [gswv_pkg::LVL_W-1:0]        lower,
  input  logic [gswv_pkg::LVL_W-1:0]        upper,
  output logic [gswv_pkg::VAR_W-1:0]        variance,
  output logic                              gated
);
  import gswv_pkg::*;

  localparam int ROW_SLOTS = 2*MAX_RADIUS + 1;
  localparam int SW    = $clog2(ROW_SLOTS);
  localparam int CB    = $clog2(MAX_ROW_LENGTH);
  localparam int RA_W  = $clog2(ROW_SLOTS*MAX_ROW_LENGTH);
  localparam int N_W   = $clog2(ROW_SLOTS*ROW_SLOTS + 1);
  localparam int CS_W  = SAMPLE_BITS + SW;
  localparam int CQ_W  = 2*SAMPLE_BITS + SW;
  localparam int WS_W  = CS_W + SW;
  localparam int WQ_W  = CQ_W + SW;
  localparam int DEN_W = 2*N_W;
  localparam int NUM_W = WQ_W + N_W;
  localparam int DF_W  = (2*WS_W > NUM_W) ? 2*WS_W : NUM_W;
  localparam int DC_W  = $clog2(DF_W);
  localparam int LN_W  = LVL_W + N_W;

  logic [SAMPLE_BITS-1:0] row_mem [ROW_SLOTS*MAX_ROW_LENGTH];
  logic [CS_W+CQ_W-1:0]   col_mem [MAX_ROW_LENGTH];

  logic [SAMPLE_BITS-1:0]   s_reg, row_q, v, v_q;
  logic [2*SAMPLE_BITS-1:0] sq_v;
  logic [CS_W-1:0]          cs;
  logic [CQ_W-1:0]          cq;
  logic [CS_W+CQ_W-1:0]     col_q;
  logic [WS_W-1:0]          ws;
  logic [WQ_W-1:0]          wq;
  logic [DF_W-1:0]          num, sq, quo;
  logic [LN_W-1:0]          un, ln;
  logic [DEN_W-1:0]         den, rem;
  logic [DEN_W:0]           rem_sh;
  logic [DC_W-1:0]          div_cnt;
  logic                     gate;
  logic [63:0]              quo_w;
  logic [RA_W-1:0]          wr_addr, rd_addr;

  assign wr_addr = RA_W'(slot_l) * RA_W'(MAX_ROW_LENGTH) + RA_W'(col_l);
  assign rd_addr = RA_W'(rd_slot) * RA_W'(MAX_ROW_LENGTH) + RA_W'(col_l);
  assign v       = cmd.use_sample ? s_reg : row_q;
  assign rem_sh  = {rem, quo[DF_W-1]};
  assign quo_w   = 64'(quo);

  assign sta.gate     = gate;
  assign sta.div_last = (int'(div_cnt) == DF_W-1);

  always_ff @(posedge clk) begin
    if (cmd.take) s_reg <= sample;
    if (cmd.row_wr) row_mem[wr_addr] <= s_reg;
    if (cmd.row_rd) row_q <= row_mem[rd_addr];
    if (cmd.col_mul) begin
      v_q  <= v;
      sq_v <= v * v;
    end
    if (cmd.col_clr) begin
      cs <= '0;
      cq <= '0;
    end else if (cmd.col_acc) begin
      cs <= cs + CS_W'(v_q);
      cq <= cq + CQ_W'(sq_v);
    end
    if (cmd.col_wr) col_mem[col_l] <= {cs, cq};
    if (cmd.win_rd) col_q <= col_mem[win_col];
    if (cmd.win_clr) begin
      ws <= '0;
      wq <= '0;
    end else if (cmd.win_acc) begin
      ws <= ws + WS_W'(col_q[CS_W+CQ_W-1:CQ_W]);
      wq <= wq + WQ_W'(col_q[CQ_W-1:0]);
    end
    if (cmd.fin_mul) begin
      num <= DF_W'(n * wq);
      sq  <= DF_W'(ws * ws);
      un  <= upper * LN_W'(n);
      ln  <= lower * LN_W'(n);
      den <= DEN_W'(n) * DEN_W'(n - 1'b1);
    end
    if (cmd.fin_eval) begin
      gate    <= (n == N_W'(1)) || (LN_W'(ws) > un) || (LN_W'(ws) < ln);
      quo     <= (num >= sq) ? num - sq : '0;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      // restoring divide, one quotient bit per cycle
      if (rem_sh >= {1'b0, den}) begin
        rem <= DEN_W'(rem_sh - {1'b0, den});
        quo <= {quo[DF_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DEN_W-1:0];
        quo <= {quo[DF_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.out_load) begin
      gated <= gate;
      if (gate) begin
        variance <= '0;
      end else if (quo_w > VAR_MAX) begin
        variance <= VAR_W'(VAR_MAX);
      end else begin
        variance <= quo_w[VAR_W-1:0];
      end
    end
    if (rst) begin
      gate <= 1'b0;
    end
  end

endmodule

/* hw/rtl/gated_sliding_window_variance.sv */
// channel   dir  handshake                 payload
// in        in   in_valid / in_stall       sample, frame_end
// out       out  out_valid / out_stall     variance, gated, last
// cfg       in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One sample at a time. A sample before the window rows are complete is only
// written to the row store; with the rows complete but no full window, the
// column sum over 2*vr+1 rows follows. A full window adds a window sum over
// 2*hr+1 columns, the final products and gate, the divider at one quotient
// bit per cycle (48 bits at default widths; cut short when gated) and the
// output register load, delayed while an earlier result still sits stalled
// there. Column sums and the divide are the serial loops that set the pace.
// Reset: synchronous, active high; clears control, config and frame position.
// The row store and column sums are always written before read in a frame,
// so there is no clearing pass.
// The next sample is taken while a finished result waits in the output
// register; a stalled output holds its value until transferred.
module gated_sliding_window_variance #(
  parameter int MAX_ROW_LENGTH = gswv_pkg::DEF_MAX_ROW_LENGTH,
  parameter int MAX_RADIUS     = gswv_pkg::DEF_MAX_RADIUS,
  parameter int SAMPLE_BITS    = gswv_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [SAMPLE_BITS-1:0]          sample,
  input  logic                            frame_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gswv_pkg::VAR_W-1:0]      variance,
  output logic                            gated,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gswv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gswv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gswv_pkg::*;

  localparam int ROW_SLOTS = 2*MAX_RADIUS + 1;
  localparam int SW  = $clog2(ROW_SLOTS);
  localparam int CB  = $clog2(MAX_ROW_LENGTH);
  localparam int N_W = $clog2(ROW_SLOTS*ROW_SLOTS + 1);

  cmd_t           cmd;
  sta_t           sta;
  logic [CB-1:0]  col_l, win_col;
  logic [SW-1:0]  slot_l, rd_slot;
  logic [N_W-1:0] n;
  logic [LVL_W-1:0] lower, upper;

  // sequencer: config, frame position, loop counts, handshakes
  gswv_ctrl #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .frame_end(frame_end),
    .out_valid(out_valid), .out_stall(out_stall), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sta(sta),
    .col_l(col_l), .slot_l(slot_l), .rd_slot(rd_slot), .win_col(win_col),
    .n(n), .lower(lower), .upper(upper)
  );

  // row store, column sums, window sums, gate and divider
  gswv_datapath #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
    .MAX_RADIUS(MAX_RADIUS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cmd(cmd), .sta(sta),
    .sample(sample),
    .col_l(col_l), .slot_l(slot_l), .rd_slot(rd_slot), .win_col(win_col),
    .n(n), .lower(lower), .upper(upper),
    .variance(variance), .gated(gated)
  );

endmodule

/* hw/rtl/gswv_chk.sv */
module gswv_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [30:0] variance,
  input logic        gated,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(variance) && $stable(gated) && $stable(last))
    else $error("stalled result changed");

  a_gate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && gated |-> variance == 31'd0)
    else $error("gated result not zero");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind gated_sliding_window_variance gswv_chk u_gswv_chk (.*);

/* tb/tb_gated_sliding_window_variance.sv */
module tb_gated_sliding_window_variance;
  timeunit 1ns;
  timeprecision 1ps;
  import gswv_pkg::*;

  localparam int ROW_SLOTS   = 2 * DEF_MAX_RADIUS + 1;
  localparam int MAX_LEN     = DEF_MAX_ROW_LENGTH;
  // settle time after the last queued result, well past the worst full window
  localparam int SETTLE      = 300;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RAND_ITEMS  = 1650;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [15:0]           sample = '0;
  logic                  frame_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VAR_W-1:0]      variance;
  logic                  gated;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gated_sliding_window_variance DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .frame_end(frame_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .variance(variance), .gated(gated), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [VAR_W-1:0] variance;
    logic             gated;
    logic             last;
  } window_result_t;

  window_result_t expected_windows[$];
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int burst_left = 0;
  int gap_max = 0;
  int stall_mode = 0;

  // shadow copy of config registers and frame position
  logic [LEN_W-1:0] sh_len;
  logic [RAD_W-1:0] sh_hr, sh_vr;
  logic [LVL_W-1:0] sh_lo, sh_hi;
  logic [15:0]      img_rows [ROW_SLOTS][MAX_LEN];
  longint unsigned  col_sum [MAX_LEN];
  longint unsigned  col_sq  [MAX_LEN];
  int unsigned      pos_col, pos_row, pos_slot;

  initial begin
    forever #10 clk = ~clk;
  end

  // cycle counter doubles as the timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL gated_sliding_window_variance");
      $finish;
    end
  end

  // receiver back-pressure: stall pattern redrawn at random from four kinds
  always @(posedge clk) begin
    if (cycles % 256 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 80);
      default: out_stall <= ((cycles / 8) % 2 == 1);
    endcase
  end

  task automatic report(input string what);
    $display("mismatch @%0d: %s", cycles, what);
    errors++;
  endtask

  // compare every output transfer against the oldest prediction
  always @(posedge clk) begin
    window_result_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_windows.size() == 0) begin
        report($sformatf("unexpected result var=%0d gated=%0b last=%0b",
                         variance, gated, last));
      end else begin
        exp_w = expected_windows.pop_front();
        if (variance !== exp_w.variance)
          report($sformatf("variance %0d, want %0d", variance, exp_w.variance));
        if (gated !== exp_w.gated)
          report($sformatf("gated %0b, want %0b", gated, exp_w.gated));
        if (last !== exp_w.last)
          report($sformatf("last %0b, want %0b", last, exp_w.last));
      end
    end
  end

  function automatic void restart_position();
    pos_col  = 0;
    pos_row  = 0;
    pos_slot = 0;
  endfunction

  // advance the shadow image by one sample, queue the window it completes
  task automatic predict_variance(input logic [15:0] s, input logic fe);
    int unsigned     len, xr, yr, col;
    bit              rows_ok, gate;
    longint unsigned cs, cq, v, n, ws, wq, num, sq, diff, var_q;
    window_result_t  r;
    len = sh_len;
    if (len == 0) len = 1;
    if (len > MAX_LEN) len = MAX_LEN;
    xr  = (sh_hr > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : sh_hr;
    yr  = (sh_vr > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : sh_vr;
    col = pos_col;
    if (col >= len) col = 0;
    if (pos_slot >= ROW_SLOTS) pos_slot = 0;
    img_rows[pos_slot][col] = s;
    rows_ok = pos_row >= 2 * yr;
    if (rows_ok) begin
      cs = 0;
      cq = 0;
      for (int unsigned k = 0; k <= 2 * yr; k++) begin
        v = img_rows[(pos_slot + ROW_SLOTS - k) % ROW_SLOTS][col];
        cs += v;
        cq += v * v;
      end
      col_sum[col] = cs;
      col_sq[col]  = cq;
    end
    if (rows_ok && col >= 2 * xr) begin
      n  = (2 * xr + 1) * (2 * yr + 1);
      ws = 0;
      wq = 0;
      for (int unsigned j = col - 2 * xr; j <= col; j++) begin
        ws += col_sum[j];
        wq += col_sq[j];
      end
      gate = (n == 1) || (ws > longint'(sh_hi) * n) || (ws < longint'(sh_lo) * n);
      var_q = 0;
      if (!gate) begin
        num  = n * wq;
        sq   = ws * ws;
        diff = (num >= sq) ? num - sq : 0;
        var_q = diff / (n * (n - 1));
        if (var_q > VAR_MAX) var_q = VAR_MAX;
      end
      r.variance = var_q[VAR_W-1:0];
      r.gated    = gate;
      r.last     = fe;
      expected_windows.push_back(r);
    end
    if (fe) begin
      restart_position();
    end else if (col + 1 >= len) begin
      pos_col = 0;
      if (pos_row < 2 * DEF_MAX_RADIUS) pos_row++;
      pos_slot = (pos_slot + 1) % ROW_SLOTS;
    end else begin
      pos_col = col + 1;
    end
  endtask

  // one input transfer, with bursty random gaps in front
  task automatic send_sample(input logic [15:0] s, input logic fe);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid  <= 1'b1;
    sample    <= s;
    frame_end <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_variance(s, fe);
    burst_left--;
    items_sent++;
  endtask

  // hold off input until every queued result is out, then let the core settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ROW_LENGTH:   begin sh_len = data[LEN_W-1:0]; restart_position(); end
      CFG_HORIZ_RADIUS: begin sh_hr  = data[RAD_W-1:0]; restart_position(); end
      CFG_VERT_RADIUS:  begin sh_vr  = data[RAD_W-1:0]; restart_position(); end
      CFG_LOWER_LEVEL:  begin sh_lo  = data;            restart_position(); end
      CFG_UPPER_LEVEL:  begin sh_hi  = data;            restart_position(); end
      default: ;
    endcase
    @(posedge clk);
  endtask

  // upper data bits ride along to check masking of narrow registers
  task automatic set_config(input int len, input int hr, input int vr, input int lo,
                            input int hi);
    logic [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    write_reg(CFG_ROW_LENGTH,   {junk[15:11], 11'(len)});
    write_reg(CFG_HORIZ_RADIUS, {junk[15:3], 3'(hr)});
    write_reg(CFG_VERT_RADIUS,  {junk[12:0], 3'(vr)});
    write_reg(CFG_LOWER_LEVEL,  16'(lo));
    write_reg(CFG_UPPER_LEVEL,  16'(hi));
  endtask

  function automatic logic [15:0] gen_sample(input int base, input int spread);
    int v;
    v = base - spread / 2 + int'($urandom_range(0, spread));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // reset values: 1024-wide rows, so a short frame yields nothing
  task automatic test_reset_defaults();
    for (int i = 0; i < 4; i++) send_sample(gen_sample(32768, 65535), i == 3);
    drain_results();
  endtask

  // row length above max acts as max; zero acts as one
  task automatic test_row_length_extremes();
    set_config(2047, 7, 0, 0, 65535);
    for (int i = 0; i < 16; i++) send_sample((i % 2) ? 16'hFFFF : 16'h0000, i == 15);
    drain_results();
    set_config(0, 0, 1, 0, 65535);
    for (int i = 0; i < 3; i++) send_sample(16'hFFFF, i == 2);
    drain_results();
  endtask

  // 1x1 window always gates
  task automatic test_single_pixel_window();
    set_config(3, 0, 0, 0, 65535);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h5A5A, 1'b1);
    drain_results();
  endtask

  // lower above upper: everything gated; also window wider than the row
  task automatic test_empty_levels_and_wide_window();
    set_config(3, 1, 1, 200, 100);
    for (int i = 0; i < 9; i++) send_sample(gen_sample(150, 100), i == 8);
    drain_results();
    set_config(4, 3, 0, 0, 65535);
    for (int i = 0; i < 4; i++) send_sample(16'hFFFF, i == 3);
    drain_results();
  endtask

  // indexes past the register list must not disturb the frame
  task automatic test_unused_index();
    set_config(3, 1, 0, 0, 65535);
    send_sample(16'h1234, 1'b0);
    drain_results();
    for (int i = 5; i < 8; i++) write_reg(CFG_IDX_W'(i), 16'($urandom_range(0, 65535)));
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b1);
    drain_results();
  endtask

  // random configs, mostly well-formed frames, some cut short mid-row
  task automatic test_random_frames();
    int len, hr, vr, lo, hi, base, spread, rows, frames, total, cut;
    while (items_sent < RAND_ITEMS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
      if ($urandom_range(0, 9) < 8) hr = $urandom_range(0, ((len - 1) / 2 > 7) ? 7 : (len - 1) / 2);
      else hr = $urandom_range(0, 7);
      vr     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
      base   = $urandom_range(0, 65535);
      spread = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 4000);
      case ($urandom_range(0, 2))
        0: begin lo = 0; hi = 65535; end
        1: begin
          lo = (base > 1500) ? base - $urandom_range(0, 1500) : 0;
          hi = base + $urandom_range(0, 1500);
          if (hi > 65535) hi = 65535;
        end
        default: begin lo = $urandom_range(0, 65535); hi = $urandom_range(0, 65535); end
      endcase
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      set_config(len, hr, vr, lo, hi);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        rows  = 2 * vr + 1 + $urandom_range(0, 2);
        if (len * rows > 200) rows = (200 / len > 0) ? 200 / len : 1;
        total = len * rows;
        cut   = ($urandom_range(0, 6) == 0) ? $urandom_range(1, total) : total;
        for (int i = 0; i < cut; i++) send_sample(gen_sample(base, spread), i == cut - 1);
      end
      drain_results();
    end
  endtask

  initial begin
    sh_len = 11'd1024;
    sh_hr  = 3'd1;
    sh_vr  = 3'd1;
    sh_lo  = 16'd0;
    sh_hi  = 16'hFFFF;
    restart_position();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_row_length_extremes();
    test_single_pixel_window();
    test_empty_levels_and_wide_window();
    test_unused_index();
    test_random_frames();

    drain_results();
    if (errors == 0 && expected_windows.size() == 0) begin
      $display("PASS gated_sliding_window_variance");
    end else begin
      $display("FAIL gated_sliding_window_variance");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/gswv_pkg.sv
hw/rtl/gswv_ctrl.sv
hw/rtl/gswv_datapath.sv
hw/rtl/gated_sliding_window_variance.sv
hw/rtl/gswv_chk.sv
tb/tb_gated_sliding_window_variance.sv
